>>> hw/rtl/pba_pkg.sv
// Page bitmap allocator: shared types and code constants.
// No dependencies.
package pba_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [2:0] status_t;

  localparam mode_t MODE_CLAIM = 2'd0;
  localparam mode_t MODE_ALLOC = 2'd1;
  localparam mode_t MODE_FREE  = 2'd2;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_RANGE   = 3'd1;
  localparam status_t ST_USED    = 3'd2;
  localparam status_t ST_NONE    = 3'd3;
  localparam status_t ST_NOTUSED = 3'd4;

  localparam int BYTE_BITS = 8;

endpackage

>>> hw/rtl/pba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/page_bitmap_allocator_core.sv
// Claim/free read-modify-write the map byte in S_RMW, and immediate failures pass through S_DONE;
// allocate reads map bytes in S_SCAN, up to ceil(page_count/8) of them, until a clear bit is found.
// One request at a time, limited by the usage map read-modify-write and byte scan.
// The next request is taken while a finished result waits in the output register.
// Reset (rst_n, synchronous): a clearing pass zeroes the usage map, one byte per cycle,
// with in_ready low; cfg writes are taken throughout.
// Top level; depends on pba_pkg and pba_ram.
module page_bitmap_allocator_core #(
  parameter int MAX_PAGES = 4096,
  parameter int ATTR_BITS = 8,
  localparam int PAGE_W = $clog2(MAX_PAGES),
  localparam int CNT_W = $clog2(MAX_PAGES + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pba_pkg::mode_t        in_mode,
  input  logic [PAGE_W-1:0]     in_page_index,
  input  logic [ATTR_BITS-1:0]  in_attribute,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pba_pkg::status_t      out_status,
  output logic [PAGE_W-1:0]     out_result_page,
  output logic [CNT_W-1:0]      out_free_pages,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata
);

  localparam int MAP_BYTES = (MAX_PAGES + 7) / 8;
  localparam int BA_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int FULL_W = BA_W + 3;
  localparam int CMP_W = (FULL_W + 1 > CNT_W) ? FULL_W + 1 : CNT_W;
  localparam int RST_EFF = (4096 > MAX_PAGES) ? MAX_PAGES : 4096;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RMW   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [BA_W-1:0]         clr_r, clr_nxt;
  logic [BA_W-1:0]         scan_r, scan_nxt;
  logic [CNT_W-1:0]        eff_r, eff_nxt;
  logic [CNT_W-1:0]        free_r, free_nxt;
  pba_pkg::mode_t          mode_r;
  logic [PAGE_W-1:0]       idx_r;
  logic [ATTR_BITS-1:0]    attr_r;
  pba_pkg::status_t        stat_r, stat_nxt;
  logic                    out_valid_r;
  pba_pkg::status_t        out_status_r;
  logic [PAGE_W-1:0]       out_page_r;
  logic [CNT_W-1:0]        out_free_r;

  logic                                  accept, slot_free, commit;
  logic                                  map_we, map_re, attr_we;
  logic [BA_W-1:0]                       map_waddr, map_raddr;
  logic [pba_pkg::BYTE_BITS-1:0]         map_wdata, map_rdata, bit_mask;
  logic [CNT_W-1:0]                      free_upd, eff_new;
  pba_pkg::status_t                      res_status;
  logic [PAGE_W-1:0]                     res_page;
  logic                                  bit_used, found, more;
  logic [2:0]                            jsel;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign bit_mask  = pba_pkg::BYTE_BITS'(1) << idx_r[2:0];
  assign bit_used  = map_rdata[idx_r[2:0]];
  assign eff_new   = (cfg_wdata > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : cfg_wdata;
  assign more      = (CMP_W'({scan_r, 3'b000}) + CMP_W'(8)) < CMP_W'(eff_r);

  // lowest clear bit of the current byte that lies below the page count
  always_comb begin
    found = 1'b0;
    jsel  = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (!map_rdata[j] && (CMP_W'({scan_r, 3'(j)}) < CMP_W'(eff_r))) begin
        found = 1'b1;
        jsel  = 3'(j);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    scan_nxt   = scan_r;
    stat_nxt   = stat_r;
    map_we     = 1'b0;
    map_waddr  = BA_W'(idx_r >> 3);
    map_wdata  = map_rdata;
    map_re     = 1'b0;
    map_raddr  = BA_W'(in_page_index >> 3);
    attr_we    = 1'b0;
    commit     = 1'b0;
    res_status = pba_pkg::ST_RANGE;
    res_page   = '0;
    free_upd   = free_r;
    unique case (state_r)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        map_wdata = '0;
        if (clr_r == BA_W'(MAP_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + BA_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          priority if (in_mode == pba_pkg::MODE_ALLOC && free_r != '0) begin
            map_re    = 1'b1;
            map_raddr = '0;
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end else if ((in_mode == pba_pkg::MODE_CLAIM || in_mode == pba_pkg::MODE_FREE)
                       && (CMP_W'(in_page_index) < CMP_W'(eff_r))) begin
            map_re    = 1'b1;
            state_nxt = S_RMW;
          end else begin
            stat_nxt  = (in_mode == pba_pkg::MODE_ALLOC) ? pba_pkg::ST_NONE
                                                         : pba_pkg::ST_RANGE;
            state_nxt = S_DONE;
          end
        end
      end
      S_RMW: begin
        commit = slot_free;
        if (mode_r == pba_pkg::MODE_CLAIM) begin
          if (bit_used) begin
            res_status = pba_pkg::ST_USED;
          end else begin
            res_status = pba_pkg::ST_OK;
            res_page   = idx_r;
            map_we     = commit;
            attr_we    = commit;
            map_wdata  = map_rdata | bit_mask;
            free_upd   = (free_r != '0) ? free_r - CNT_W'(1) : free_r;
          end
        end else begin
          if (!bit_used) begin
            res_status = pba_pkg::ST_NOTUSED;
          end else begin
            res_status = pba_pkg::ST_OK;
            res_page   = idx_r;
            map_we     = commit;
            map_wdata  = map_rdata & ~bit_mask;
            free_upd   = (free_r < eff_r) ? free_r + CNT_W'(1) : free_r;
          end
        end
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        map_waddr = scan_r;
        if (found) begin
          commit     = slot_free;
          res_status = pba_pkg::ST_OK;
          res_page   = PAGE_W'({scan_r, jsel});
          map_we     = commit;
          attr_we    = commit;
          map_wdata  = map_rdata | (pba_pkg::BYTE_BITS'(1) << jsel);
          free_upd   = (free_r != '0) ? free_r - CNT_W'(1) : free_r;
        end else if (more) begin
          map_re    = 1'b1;
          map_raddr = scan_r + BA_W'(1);
          scan_nxt  = scan_r + BA_W'(1);
        end else begin
          commit     = slot_free;
          res_status = pba_pkg::ST_NONE;
        end
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        commit     = slot_free;
        res_status = stat_r;
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign free_nxt = cfg_we ? eff_new : (commit ? free_upd : free_r);
  assign eff_nxt  = cfg_we ? eff_new : eff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      scan_r      <= '0;
      stat_r      <= pba_pkg::ST_OK;
      eff_r       <= CNT_W'(RST_EFF);
      free_r      <= CNT_W'(RST_EFF);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      scan_r  <= scan_nxt;
      stat_r  <= stat_nxt;
      eff_r   <= eff_nxt;
      free_r  <= free_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      idx_r  <= in_page_index;
      attr_r <= in_attribute;
    end
    if (commit) begin
      out_status_r <= res_status;
      out_page_r   <= res_page;
      out_free_r   <= free_upd;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_page = out_page_r;
  assign out_free_pages  = out_free_r;

  pba_ram #(
    .WIDTH (pba_pkg::BYTE_BITS),
    .DEPTH (MAP_BYTES)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // attribute store: write-only from this block
  pba_ram #(
    .WIDTH (ATTR_BITS),
    .DEPTH (MAX_PAGES)
  ) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (res_page),
    .wdata (attr_r),
    .re    (1'b0),
    .raddr ('0),
    .rdata ()
  );

endmodule
